// File: rtl/rtti_pkg.sv
// Package for the radix text-to-integer converter.
// Holds the character constants, the parse phase type and the character class record.
// No dependencies.
package rtti_pkg;

    // Default size of the digit alphabet.
    localparam int unsigned MAX_SYMBOLS_DEF = 16;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned RADIX_W  = 5;
    localparam int unsigned SYMREG_W = 64;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // Characters with a fixed meaning.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        PH_SPACE = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_STOP  = 2'd3
    } t_phase;

    // Classification of one character, taken before the parse stage.
    typedef struct packed {
        logic nul;
        logic space;
        logic plus;
        logic minus;
        logic hit;
    } t_char_class;

endpackage

// File: rtl/rtti_class.sv
// Character classifier: whitespace, sign and terminator detection plus the
// alphabet lookup that turns a character into a digit. Uses rtti_pkg.
module rtti_class
    import rtti_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int unsigned DIGIT_W     = $clog2(MAX_SYMBOLS)
) (
    input  logic [CHAR_W-1:0]          i_ch,
    input  logic [2*SYMREG_W-1:0]      i_symbols,
    input  logic [RADIX_W-1:0]         i_eff_radix,
    output t_char_class                o_cls,
    output logic [DIGIT_W-1:0]         o_digit
);

    logic                hit;
    logic [DIGIT_W-1:0]  digit;

    // Scan from the top so that the lowest matching symbol wins.
    always_comb begin
        hit   = 1'b0;
        digit = '0;
        for (int j = MAX_SYMBOLS - 1; j >= 0; j--) begin
            if ((RADIX_W'(j) < i_eff_radix) && (i_symbols[CHAR_W*j +: CHAR_W] == i_ch)) begin
                hit   = 1'b1;
                digit = DIGIT_W'(j);
            end
        end
    end

    // A zero character always terminates and is never taken as a digit.
    always_comb begin
        o_cls.nul   = (i_ch == CH_NUL);
        o_cls.space = (i_ch == CH_SPACE) || (i_ch == CH_TAB) || (i_ch == CH_LF)
                   || (i_ch == CH_CR) || (i_ch == CH_VT) || (i_ch == CH_FF);
        o_cls.plus  = (i_ch == CH_PLUS);
        o_cls.minus = (i_ch == CH_MINUS);
        o_cls.hit   = hit && (i_ch != CH_NUL);
        o_digit     = digit;
    end

endmodule

// File: rtl/rtti_parse.sv
// Parse stage: phase state machine, sign flag, multiply-add accumulator and
// the output register. Uses rtti_pkg.
module rtti_parse
    import rtti_pkg::*;
#(
    parameter int unsigned DIGIT_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  t_char_class                i_cls,
    input  logic [DIGIT_W-1:0]         i_digit,
    input  logic [RADIX_W-1:0]         i_eff_radix,
    output logic                       o_take,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic signed [VALUE_W-1:0]  o_m_tdata
);

    t_phase                r_phase, n_phase;
    logic                  r_neg, n_neg;
    logic [VALUE_W-1:0]    r_acc, n_acc;
    logic                  r_out_vld, n_out_vld;
    logic [VALUE_W-1:0]    r_out, n_out;

    logic                  do_flip;
    logic                  do_acc;
    logic                  take;
    logic [VALUE_W-1:0]    product;
    logic [VALUE_W-1:0]    digit_ext;

    // A terminator may only move on when the output register is free.
    assign take   = i_valid && (!i_cls.nul || !r_out_vld || i_m_tready);
    assign o_take = take;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (take) begin
            if (i_cls.nul) begin
                n_phase = PH_SPACE;
            end else begin
                unique case (r_phase)
                    PH_SPACE, PH_SIGN: begin
                        if (r_phase == PH_SPACE && i_cls.space) begin
                            n_phase = PH_SPACE;
                        end else if (i_cls.plus || i_cls.minus) begin
                            n_phase = PH_SIGN;
                        end else if (i_cls.hit) begin
                            n_phase = PH_DIGIT;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                    PH_DIGIT: n_phase = i_cls.hit ? PH_DIGIT : PH_STOP;
                    PH_STOP:  n_phase = PH_STOP;
                    default:  n_phase = PH_SPACE;
                endcase
            end
        end
    end

    // Actions for the current beat.
    always_comb begin
        do_flip = 1'b0;
        do_acc  = 1'b0;
        if (take && !i_cls.nul) begin
            unique case (r_phase)
                PH_SPACE, PH_SIGN: begin
                    if (!(r_phase == PH_SPACE && i_cls.space)) begin
                        do_flip = i_cls.minus;
                        do_acc  = !i_cls.plus && !i_cls.minus && i_cls.hit;
                    end
                end
                PH_DIGIT: do_acc = i_cls.hit;
                PH_STOP:  do_acc = 1'b0;
                default:  do_acc = 1'b0;
            endcase
        end
    end

    assign product   = r_acc * VALUE_W'(i_eff_radix);
    assign digit_ext = VALUE_W'(i_digit);

    always_comb begin
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_m_tready;
        if (take && i_cls.nul) begin
            n_out     = r_acc;
            n_out_vld = 1'b1;
            n_neg     = 1'b0;
            n_acc     = '0;
        end else begin
            if (do_flip) begin
                n_neg = !r_neg;
            end
            if (do_acc) begin
                n_acc = r_neg ? (product - digit_ext) : (product + digit_ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SPACE;
            r_neg     <= 1'b0;
            r_acc     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_acc     <= n_acc;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

endmodule

// File: rtl/radix_text_to_integer.sv
// Top level of the radix text-to-integer converter: configuration registers,
// the classified input register and the parse stage. Uses rtti_pkg,
// rtti_class and rtti_parse.
//
//  Channel  Direction  Signals                        Payload
//  s        in         i_s_tvalid/o_s_tready/i_s_tdata  ch (8 bits)
//  m        out        o_m_tvalid/i_m_tready/o_m_tdata  value (32 bits, signed)
//  cfg      in         i_cfg_wr_en/i_cfg_index/i_cfg_data  register write
//
// One character is taken every cycle unless a zero character waits for a stalled
// output; a stalled output holds back only zero characters and those behind them.
// A result is held in the output register. The rate is set by the multiply-add in
// the parse stage, which handles one character a cycle. Reset is synchronous and
// active low and returns the parser to whitespace skipping with a zero value.
module radix_text_to_integer
    import rtti_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [CHAR_W-1:0]          i_s_tdata,   // [7:0] ch
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic signed [VALUE_W-1:0]  o_m_tdata,   // [31:0] value
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [SYMREG_W-1:0]        i_cfg_data
);

    localparam int unsigned DIGIT_W = $clog2(MAX_SYMBOLS);

    logic [SYMREG_W-1:0]  r_sym_low;
    logic [SYMREG_W-1:0]  r_sym_high;
    logic [RADIX_W-1:0]   r_radix;
    logic [RADIX_W-1:0]   eff_radix;

    t_char_class          cls;
    logic [DIGIT_W-1:0]   digit;
    t_char_class          r_cls;
    logic [DIGIT_W-1:0]   r_digit;
    logic                 r_ch_vld, n_ch_vld;
    logic                 take;
    logic                 accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_low  <= '0;
            r_sym_high <= '0;
            r_radix    <= RADIX_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SYMBOLS_LOW:  r_sym_low  <= i_cfg_data;
                CFG_SYMBOLS_HIGH: r_sym_high <= i_cfg_data;
                CFG_RADIX:        r_radix    <= i_cfg_data[RADIX_W-1:0];
                default:          r_radix    <= r_radix;
            endcase
        end
    end

    // The radix is clamped to the alphabet size for both lookup and multiply.
    assign eff_radix = (r_radix > RADIX_W'(MAX_SYMBOLS)) ? RADIX_W'(MAX_SYMBOLS) : r_radix;

    rtti_class #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .DIGIT_W     (DIGIT_W)
    ) u_class (
        .i_ch        (i_s_tdata),
        .i_symbols   ({r_sym_high, r_sym_low}),
        .i_eff_radix (eff_radix),
        .o_cls       (cls),
        .o_digit     (digit)
    );

    assign o_s_tready = !r_ch_vld || take;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_ch_vld = r_ch_vld;
        if (accept) begin
            n_ch_vld = 1'b1;
        end else if (take) begin
            n_ch_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_vld <= 1'b0;
        end else begin
            r_ch_vld <= n_ch_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls   <= cls;
            r_digit <= digit;
        end
    end

    rtti_parse #(
        .DIGIT_W     (DIGIT_W)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_ch_vld),
        .i_cls       (r_cls),
        .i_digit     (r_digit),
        .i_eff_radix (eff_radix),
        .o_take      (take),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
